FILE: design/bmpc_pkg.sv
// Shared constants and types for the banded min-plus path cost block.
// No dependencies; imported by every module of the block except bmpc_ram.
`timescale 1ns / 1ps

package bmpc_pkg;

    // Default sizes of the column stores and the saturation range
    localparam int DEF_ROWS      = 1024;
    localparam int DEF_COST_BITS = 32;

    // Fixed widths of the port fields
    localparam int IN_COST_W = 32;
    localparam int ROW_W     = 10;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO_PATH_COST = 2'd1;

    // Register reset values
    localparam logic [STEP_W-1:0]           DEF_MAX_STEP    = 4'd3;
    localparam logic signed [IN_COST_W-1:0] DEF_NO_PATH_COST = 32'sh7FFF_FFFF;

    // Configuration seen by the engine
    typedef struct packed {
        logic [STEP_W-1:0]           max_step;
        logic signed [IN_COST_W-1:0] no_path_cost;
    } cfg_t;

    // One finished result
    typedef struct packed {
        logic signed [IN_COST_W-1:0] total_cost;
        logic                        saturated;
    } res_t;

endpackage

FILE: design/bmpc_ram.sv
// Simple dual-port column cost store: one write port, one registered read port.
// No package dependencies; instantiated twice by bmpc_engine as ping-pong banks.
`timescale 1ns / 1ps

module bmpc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/bmpc_engine.sv
// Sequencer and datapath: range clipping, min scan over the previous column,
// saturating add and write back. Depends on bmpc_pkg and bmpc_ram.
`timescale 1ns / 1ps

module bmpc_engine #(
    parameter int ROWS      = bmpc_pkg::DEF_ROWS,
    parameter int COST_BITS = bmpc_pkg::DEF_COST_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_take,
    output logic                                   in_ready,
    input  logic signed [bmpc_pkg::IN_COST_W-1:0]  in_cost,
    input  logic [bmpc_pkg::ROW_W-1:0]             in_row,
    input  logic [bmpc_pkg::ROW_W-1:0]             in_band_top,
    input  logic [bmpc_pkg::ROW_W-1:0]             in_band_bottom,
    input  logic                                   in_first_column,
    input  logic                                   in_column_end,
    input  bmpc_pkg::cfg_t                         cfg,
    input  logic                                   out_free,
    output logic                                   res_valid,
    output bmpc_pkg::res_t                         res
);

    import bmpc_pkg::*;

    localparam int IDX_W   = $clog2(ROWS);
    localparam int STORE_W = (COST_BITS > IN_COST_W) ? COST_BITS : IN_COST_W;
    localparam int SUM_W   = STORE_W + 1;
    localparam int RNG_W   = ((IDX_W > ROW_W) ? IDX_W : ROW_W) + 2;

    localparam logic signed [RNG_W-1:0] ROW_LAST = RNG_W'(ROWS - 1);
    localparam logic signed [RNG_W-1:0] ROW_LIM  = RNG_W'(ROWS);
    localparam logic signed [SUM_W-1:0] CMAX =
        SUM_W'((64'sd1 <<< (COST_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] CMIN = -CMAX - SUM_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Item held for the duration of its work
    logic signed [IN_COST_W-1:0] cost_reg;
    logic [ROW_W-1:0]            row_reg;
    logic [ROW_W-1:0]            top_reg;
    logic [ROW_W-1:0]            bottom_reg;
    logic                        end_reg;
    logic                        band_reg;
    logic                        store_reg;

    // Previous column band and bank select
    logic [ROW_W-1:0] prev_top_reg;
    logic [ROW_W-1:0] prev_bottom_reg;
    logic             bank_reg;

    // Scan state
    logic [IDX_W-1:0]          addr_reg;
    logic [IDX_W-1:0]          hi_reg;
    logic                      rd_pend_reg;
    logic signed [STORE_W-1:0] best_reg;

    // Range computation on the incoming item
    logic signed [RNG_W-1:0] row_s, step_s, ptop_s, pbot_s;
    logic signed [RNG_W-1:0] lo_a, lo_c, hi_a, hi_b, hi_c;
    logic                    in_band, range_ok, row_ok;

    always_comb begin
        row_s  = $signed({{(RNG_W-ROW_W){1'b0}}, in_row});
        step_s = $signed({{(RNG_W-STEP_W){1'b0}}, cfg.max_step});
        ptop_s = $signed({{(RNG_W-ROW_W){1'b0}}, prev_top_reg});
        pbot_s = $signed({{(RNG_W-ROW_W){1'b0}}, prev_bottom_reg});
        lo_a   = row_s - step_s;
        // previous band top is never negative, so this also clips at row zero
        lo_c   = (lo_a < ptop_s) ? ptop_s : lo_a;
        hi_a   = row_s + step_s;
        hi_b   = (hi_a > pbot_s) ? pbot_s : hi_a;
        hi_c   = (hi_b > ROW_LAST) ? ROW_LAST : hi_b;
        in_band  = !in_first_column && (in_row >= in_band_top) &&
                   (in_row <= in_band_bottom);
        range_ok = (lo_c <= hi_c);
        row_ok   = (row_s < ROW_LIM);
    end

    // Column banks: the current column is written to bank bank_reg,
    // the previous column is read from the other one
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [STORE_W-1:0]   wr_data;
    logic [STORE_W-1:0]   q0, q1;
    logic signed [STORE_W-1:0] prev_q;

    bmpc_ram #(.DEPTH(ROWS), .WIDTH(STORE_W)) u_bank0 (
        .aclk  (aclk),
        .we    (wr_en && !bank_reg),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (addr_reg),
        .rdata (q0)
    );

    bmpc_ram #(.DEPTH(ROWS), .WIDTH(STORE_W)) u_bank1 (
        .aclk  (aclk),
        .we    (wr_en && bank_reg),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (addr_reg),
        .rdata (q1)
    );

    assign prev_q = $signed(bank_reg ? q0 : q1);

    // Saturating add of local and best previous cost, or local cost alone
    logic signed [SUM_W-1:0]   sum;
    logic signed [STORE_W-1:0] result;
    logic                      sat;

    always_comb begin
        sum = {{(SUM_W-IN_COST_W){cost_reg[IN_COST_W-1]}}, cost_reg} +
              {best_reg[STORE_W-1], best_reg};
        sat = 1'b0;
        if (!band_reg) begin
            result = STORE_W'(cost_reg);
        end else if (sum > CMAX) begin
            result = STORE_W'(CMAX);
            sat    = 1'b1;
        end else if (sum < CMIN) begin
            result = STORE_W'(CMIN);
            sat    = 1'b1;
        end else begin
            result = STORE_W'(sum);
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    state_next = (in_band && range_ok) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (addr_reg == hi_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    wr_en      = store_reg;
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign wr_addr    = IDX_W'(row_reg);
    assign wr_data    = result;
    assign res.total_cost = result[IN_COST_W-1:0];
    assign res.saturated  = sat;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            bank_reg        <= 1'b0;
            prev_top_reg    <= '0;
            prev_bottom_reg <= '0;
            rd_pend_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            // swap banks and band at the end of a column
            if (res_valid && end_reg) begin
                bank_reg        <= !bank_reg;
                prev_top_reg    <= top_reg;
                prev_bottom_reg <= bottom_reg;
            end
        end
    end

    // Item payload and scan datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_take) begin
            cost_reg   <= in_cost;
            row_reg    <= in_row;
            top_reg    <= in_band_top;
            bottom_reg <= in_band_bottom;
            end_reg    <= in_column_end;
            band_reg   <= in_band;
            store_reg  <= row_ok;
            addr_reg   <= lo_c[IDX_W-1:0];
            hi_reg     <= hi_c[IDX_W-1:0];
            best_reg   <= STORE_W'(cfg.no_path_cost);
        end else begin
            if (rd_en) begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            // fold in the row read last cycle
            if (rd_pend_reg && (prev_q < best_reg)) begin
                best_reg <= prev_q;
            end
        end
    end

endmodule

FILE: design/banded_min_plus_path_cost_top.sv
// Banded min-plus path cost accumulation, top level: ports, configuration
// registers and output register. Depends on bmpc_pkg and bmpc_engine.
`timescale 1ns / 1ps

// One pixel is worked on at a time. A pass-through pixel (first column, outside
// its band, or with no reachable previous row) goes from acceptance through the
// finish state back to idle; an in-band pixel with n reachable previous-column
// rows (n at most 2*max_step+1) goes through a scan of those rows, a drain state
// and the finish state. The scan is paced by the single read port of the
// previous-column bank, which delivers one stored cost per cycle to the running
// minimum. Column costs live in two ping-pong banks of ROWS entries that swap
// at column_end, so no copy pass is needed and no clearing pass follows reset.
// Results wait in an output register; the next pixel is taken while one waits.

module banded_min_plus_path_cost_top #(
    parameter int ROWS      = bmpc_pkg::DEF_ROWS,
    parameter int COST_BITS = bmpc_pkg::DEF_COST_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [bmpc_pkg::IN_COST_W-1:0]  s_cost,
    input  logic [bmpc_pkg::ROW_W-1:0]             s_row,
    input  logic [bmpc_pkg::ROW_W-1:0]             s_band_top,
    input  logic [bmpc_pkg::ROW_W-1:0]             s_band_bottom,
    input  logic                                   s_first_column,
    input  logic                                   s_column_end,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bmpc_pkg::IN_COST_W-1:0]  m_total_cost,
    output logic                                   m_saturated,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bmpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bmpc_pkg::IN_COST_W-1:0]         cfg_data
);

    import bmpc_pkg::*;

    cfg_t cfg_reg;
    logic eng_ready;
    logic res_valid;
    res_t res;
    logic out_free;

    logic                        m_valid_reg;
    logic signed [IN_COST_W-1:0] m_total_cost_reg;
    logic                        m_saturated_reg;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_step     <= DEF_MAX_STEP;
            cfg_reg.no_path_cost <= DEF_NO_PATH_COST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_STEP:     cfg_reg.max_step     <= cfg_data[STEP_W-1:0];
                REG_NO_PATH_COST: cfg_reg.no_path_cost <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    assign s_ready = eng_ready;

    bmpc_engine #(.ROWS(ROWS), .COST_BITS(COST_BITS)) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_take         (s_valid && eng_ready),
        .in_ready        (eng_ready),
        .in_cost         (s_cost),
        .in_row          (s_row),
        .in_band_top     (s_band_top),
        .in_band_bottom  (s_band_bottom),
        .in_first_column (s_first_column),
        .in_column_end   (s_column_end),
        .cfg             (cfg_reg),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Output register: load a finished result, drop it on transfer
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_total_cost_reg <= res.total_cost;
            m_saturated_reg  <= res.saturated;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_total_cost = m_total_cost_reg;
    assign m_saturated  = m_saturated_reg;

endmodule

FILE: design/bmpc_checker.sv
// Port-level checks for banded_min_plus_path_cost_top, attached with bind.
// Depends on bmpc_pkg for field widths.
`timescale 1ns / 1ps

module bmpc_checker #(
    parameter int COST_BITS = bmpc_pkg::DEF_COST_BITS
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [bmpc_pkg::IN_COST_W-1:0] m_total_cost,
    input logic                                  m_saturated
);

    import bmpc_pkg::*;

    localparam logic [63:0] SAT_HI = (64'd1 << (COST_BITS - 1)) - 64'd1;
    localparam logic [63:0] SAT_LO = ~SAT_HI;

    // A held result stays put until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_cost) &&
                                $stable(m_saturated))
        else $error("result changed while stalled");

    // A clipped result carries one of the two limits
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_total_cost == $signed(SAT_HI[IN_COST_W-1:0]) ||
            m_total_cost == $signed(SAT_LO[IN_COST_W-1:0]))
        else $error("saturated result is not a limit");

    // One pixel at a time: the block is busy right after a transfer in
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second pixel taken while first in work");

    // A new result appears only after the block was busy
    a_res_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without work");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind banded_min_plus_path_cost_top bmpc_checker #(.COST_BITS(COST_BITS)) u_bmpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_total_cost (m_total_cost),
    .m_saturated  (m_saturated)
);
